[hdl/dse_pkg.sv]
// Shared types and constants for the deck shuffle engine.
package dse_pkg;
    localparam int DECK_SIZE_DEF = 52;
    localparam int MT_N = 624;
    localparam int MT_M = 397;
    localparam int SUIT_LEN = 13;
    localparam logic [31:0] MT_MATRIX = 32'h9908B0DF;
    localparam logic [31:0] MT_MULT = 32'd1812433253;

    typedef enum logic [3:0] {
        ST_IDLE, ST_INIT, ST_SEED, ST_SEEDW, ST_DRAWREQ, ST_DRAWWAIT, ST_MOD,
        ST_RDA, ST_RDB, ST_SWAP, ST_EMITRD, ST_EMIT
    } top_state_t;

    typedef enum logic [2:0] {
        MT_IDLE, MT_TW_RD0, MT_TW_RD1, MT_TW_RD2, MT_TW_WR, MT_OUT_RD, MT_OUT_TMP, MT_DONE
    } mt_state_t;

    // Generator control between sequencer and generator
    typedef struct packed {
        logic        seed_wr;
        logic [9:0]  seed_addr;
        logic [31:0] seed_data;
        logic        draw_req;
    } mt_ctl_t;

    typedef struct packed {
        logic        draw_valid;
        logic [31:0] draw;
    } mt_sts_t;

    // Tempering of one MT19937 output word
    function automatic logic [31:0] mt_temper(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & 32'h9D2C5680);
        y = y ^ ((y << 15) & 32'hEFC60000);
        y = y ^ (y >> 18);
        return y;
    endfunction
endpackage

[hdl/dse_mt.sv]
// MT19937 generator with the state words held in a synchronous memory.
module dse_mt
    import dse_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  mt_ctl_t ctl,
    output mt_sts_t sts
);
    logic [31:0] mem [MT_N];
    logic [9:0]  raddr;
    logic [31:0] rdata;
    logic        wen;
    logic [9:0]  waddr;
    logic [31:0] wdata;

    mt_state_t   state_reg, state_next;
    logic [9:0]  pos_reg, pos_next;
    logic [9:0]  idx_reg, idx_next;
    logic [31:0] wi_reg, wi_next;
    logic [31:0] w1_reg, w1_next;
    logic [31:0] out_reg, out_next;
    logic [31:0] y;

    // Hold state memory, one read and one write port
    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

    function automatic logic [9:0] wrap(input logic [10:0] v);
        return (v >= 11'(MT_N)) ? 10'(v - 11'(MT_N)) : v[9:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MT_IDLE;
            pos_reg   <= 10'(MT_N);
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        wi_reg  <= wi_next;
        w1_reg  <= w1_next;
        out_reg <= out_next;
    end

    assign y = {wi_reg[31], w1_reg[30:0]};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            MT_IDLE:    if (ctl.draw_req) state_next = (pos_reg >= 10'(MT_N)) ? MT_TW_RD0
                                                                              : MT_OUT_RD;
            MT_TW_RD0:  state_next = MT_TW_RD1;
            MT_TW_RD1:  state_next = MT_TW_RD2;
            MT_TW_RD2:  state_next = MT_TW_WR;
            MT_TW_WR:   state_next = (idx_reg == 10'(MT_N - 1)) ? MT_OUT_RD : MT_TW_RD1;
            MT_OUT_RD:  state_next = MT_OUT_TMP;
            MT_OUT_TMP: state_next = MT_DONE;
            MT_DONE:    state_next = MT_IDLE;
            default:    state_next = MT_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb
    begin
        pos_next = pos_reg;
        idx_next = idx_reg;
        wi_next  = wi_reg;
        w1_next  = w1_reg;
        out_next = out_reg;
        raddr    = '0;
        wen      = ctl.seed_wr;
        waddr    = ctl.seed_addr;
        wdata    = ctl.seed_data;
        sts.draw_valid = 1'b0;
        sts.draw       = out_reg;
        case (state_reg)
            MT_IDLE:
            begin
                // read word 0 ahead of a twist
                idx_next = '0;
                raddr    = 10'd0;
            end
            MT_TW_RD0:
            begin
                // word 0 arrives
                wi_next = rdata;
            end
            MT_TW_RD1:
            begin
                raddr = wrap(11'(idx_reg) + 11'd1);
            end
            MT_TW_RD2:
            begin
                // word i+1 arrives; read word i+M
                w1_next = rdata;
                raddr   = wrap(11'(idx_reg) + 11'(MT_M));
            end
            MT_TW_WR:
            begin
                // word i+M is in rdata; word i+1 becomes word i of the next step
                wen      = 1'b1;
                waddr    = idx_reg;
                wdata    = rdata ^ (y >> 1) ^ (y[0] ? MT_MATRIX : 32'd0);
                wi_next  = w1_reg;
                idx_next = idx_reg + 10'd1;
                if (idx_reg == 10'(MT_N - 1))
                begin
                    pos_next = '0;
                end
            end
            MT_OUT_RD:  raddr = pos_reg;
            MT_OUT_TMP:
            begin
                out_next = mt_temper(rdata);
                pos_next = pos_reg + 10'd1;
            end
            MT_DONE:    sts.draw_valid = 1'b1;
            default: ;
        endcase
    end
    // Note: at twist step i the word at i+1 is still the original, except at the last step,
    // which reads the rewritten word 0; word i+M wraps to already rewritten words for
    // i >= MT_N-MT_M, matching in-place order.

`ifndef SYNTHESIS
    a_twist_wr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == MT_TW_WR) |-> (idx_reg < 10'(MT_N))) else $error("twist index");
    a_draw_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == MT_OUT_RD) |-> (pos_reg < 10'(MT_N))) else $error("draw position");
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == MT_DONE) |-> $past(state_reg == MT_OUT_TMP)) else $error("draw order");
`endif
endmodule

[hdl/dse_mod.sv]
// Iterative remainder unit: draw mod n by restoring subtraction.
module dse_mod
    import dse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [6:0]  den,
    output logic        done,
    output logic [5:0]  rem
);
    logic [5:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic [31:0] q_reg, q_next;
    logic [6:0]  r_reg, r_next;
    logic [7:0]  trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    // Shift one dividend bit a cycle
    always_comb
    begin
        run_next = run_reg;
        cnt_next = cnt_reg;
        q_next   = q_reg;
        r_next   = r_reg;
        done     = 1'b0;
        trial    = {r_reg, q_reg[31]};
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            q_next   = num;
            r_next   = '0;
        end
        else if (run_reg)
        begin
            q_next   = {q_reg[30:0], 1'b0};
            r_next   = (trial >= {1'b0, den}) ? 7'(trial - {1'b0, den}) : trial[6:0];
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                run_next = 1'b0;
            end
        end
        else if (cnt_reg == 6'd32)
        begin
            done     = 1'b1;
            cnt_next = '0;
        end
        rem = r_reg[5:0];
    end
    // counter reaches 32 at the cycle after the last shift

`ifndef SYNTHESIS
    a_rem: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ({1'b0, rem} < den)) else $error("remainder range");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !run_reg) else $error("remainder done while running");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> (cnt_reg < 6'd32)) else $error("shift count");
`endif
endmodule

[hdl/deck_shuffle_engine.sv]
// Top level of the deck shuffle engine: sequencer, deck memory and result port.
//
// Channel | Direction | Signals                           | Transfer rule
// cfg     | in        | cfg_valid cfg_ready cfg_data      | valid & ready
// cmd     | in        | start busy reset_deck             | start & !busy
// result  | out       | strobe position card_suit ...     | strobe, one cycle
//
// Order of work: the first shuffle seeds all 624 generator words. One draw in every
// 624 first twists the whole state; each draw is followed by the remainder and the swap.
// The emit phase reads each card from the deck memory and then emits it. Reset
// clears control; the deck restores start order by a reset sweep while busy is high.
// The receiver cannot stall results.
module deck_shuffle_engine
    import dse_pkg::*;
#(
    parameter int DECK_SIZE = DECK_SIZE_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic        reset_deck,
    output logic        strobe,
    output logic [5:0]  position,
    output logic [1:0]  card_suit,
    output logic [3:0]  card_rank,
    output logic        last_card
);
    localparam int AW = (DECK_SIZE > 1) ? $clog2(DECK_SIZE) : 1;

    logic [5:0]  deck [DECK_SIZE];
    logic [AW-1:0] draddr;
    logic [5:0]  drdata;
    logic        dwen;
    logic [AW-1:0] dwaddr;
    logic [5:0]  dwdata;

    top_state_t  state_reg, state_next;
    logic [31:0] seed_reg;
    logic        seeded_reg, seeded_next;
    logic [9:0]  si_reg, si_next;
    logic [31:0] prev_reg, prev_next;
    logic [6:0]  n_reg, n_next;
    logic [AW-1:0] i_reg, i_next;
    logic [5:0]  k_reg, k_next;
    logic [5:0]  a_reg, a_next;
    logic        mod_start;
    logic        mod_done;
    logic [5:0]  mod_rem;
    logic [31:0] x;
    logic [31:0] prod;
    mt_ctl_t     mctl;
    mt_sts_t     msts;
    logic        strobe_reg;
    logic [5:0]  pos_reg;
    logic [5:0]  code_reg;
    logic        last_reg;
    logic        pend_reg;

    dse_mt u_mt (.clk(clk), .rst_n(rst_n), .ctl(mctl), .sts(msts));

    dse_mod u_mod (
        .clk(clk), .rst_n(rst_n), .start(mod_start), .num(msts.draw), .den(n_reg),
        .done(mod_done), .rem(mod_rem)
    );

    assign cfg_ready = 1'b1;

    // Hold the seed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            seed_reg <= cfg_data;
        end
    end

    // Deck memory
    always_ff @(posedge clk)
    begin
        if (dwen)
        begin
            deck[dwaddr] <= dwdata;
        end
        drdata <= deck[draddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_INIT;
            seeded_reg <= 1'b0;
            i_reg      <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            seeded_reg <= seeded_next;
            i_reg      <= i_next;
            strobe_reg <= (state_reg == ST_EMIT);
        end
    end

    always_ff @(posedge clk)
    begin
        si_reg   <= si_next;
        prev_reg <= prev_next;
        n_reg    <= n_next;
        k_reg    <= k_next;
        a_reg    <= a_next;
        if (state_reg == ST_EMIT)
        begin
            pos_reg  <= 6'(i_reg);
            code_reg <= drdata;
            last_reg <= (32'(i_reg) == DECK_SIZE - 1);
        end
    end

    assign x    = prev_reg ^ (prev_reg >> 30);
    assign prod = 32'(x * MT_MULT) + 32'(si_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:     if (32'(i_reg) == DECK_SIZE - 1)
                             state_next = pend_reg ? (seeded_reg ? ST_DRAWREQ : ST_SEED)
                                                   : ST_IDLE;
            ST_IDLE:     if (start) state_next = reset_deck ? ST_INIT
                                    : (seeded_reg ? ST_DRAWREQ : ST_SEED);
            ST_SEED:     state_next = ST_SEEDW;
            ST_SEEDW:    if (si_reg == 10'(MT_N - 1)) state_next = ST_DRAWREQ;
                         else state_next = ST_SEEDW;
            ST_DRAWREQ:  state_next = ST_DRAWWAIT;
            ST_DRAWWAIT: if (msts.draw_valid) state_next = ST_MOD;
            ST_MOD:      if (mod_done) state_next = ST_RDA;
            ST_RDA:      state_next = ST_RDB;
            ST_RDB:      state_next = ST_SWAP;
            ST_SWAP:     state_next = (n_reg == 7'd2) ? ST_EMITRD : ST_DRAWREQ;
            ST_EMITRD:   state_next = ST_EMIT;
            ST_EMIT:     state_next = (32'(i_reg) == DECK_SIZE - 1) ? ST_IDLE : ST_EMITRD;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        seeded_next = seeded_reg;
        si_next     = si_reg;
        prev_next   = prev_reg;
        n_next      = n_reg;
        i_next      = i_reg;
        k_next      = k_reg;
        a_next      = a_reg;
        mod_start   = 1'b0;
        dwen        = 1'b0;
        dwaddr      = i_reg;
        dwdata      = 6'(i_reg);
        draddr      = i_reg;
        mctl        = '0;
        busy        = (state_reg != ST_IDLE);
        case (state_reg)
            ST_INIT:
            begin
                // restore start order one entry a cycle
                dwen   = 1'b1;
                i_next = (32'(i_reg) == DECK_SIZE - 1) ? '0 : i_reg + 1'b1;
            end
            ST_IDLE:
            begin
                n_next = 7'(DECK_SIZE);
                i_next = '0;
            end
            ST_SEED:
            begin
                mctl.seed_wr   = 1'b1;
                mctl.seed_addr = '0;
                mctl.seed_data = seed_reg;
                prev_next      = seed_reg;
                si_next        = 10'd1;
                seeded_next    = 1'b1;
            end
            ST_SEEDW:
            begin
                mctl.seed_wr   = 1'b1;
                mctl.seed_addr = si_reg;
                mctl.seed_data = prod;
                prev_next      = prod;
                si_next        = si_reg + 10'd1;
            end
            ST_DRAWREQ:  mctl.draw_req = 1'b1;
            ST_DRAWWAIT:
            begin
                mod_start = msts.draw_valid;
            end
            ST_MOD:
            begin
                k_next = mod_rem;
                draddr = AW'(n_reg - 7'd1);
            end
            ST_RDA:
            begin
                // entry n-1 arrives; read entry k
                a_next = drdata;
                draddr = k_reg[AW-1:0];
            end
            ST_RDB:
            begin
                // entry k arrives; write it to n-1
                dwen   = 1'b1;
                dwaddr = AW'(n_reg - 7'd1);
                dwdata = drdata;
            end
            ST_SWAP:
            begin
                // old entry n-1 to k
                dwen   = 1'b1;
                dwaddr = k_reg[AW-1:0];
                dwdata = a_reg;
                n_next = n_reg - 7'd1;
                i_next = '0;
            end
            ST_EMITRD:   draddr = i_reg;
            ST_EMIT:     i_next = (32'(i_reg) == DECK_SIZE - 1) ? '0 : i_reg + 1'b1;
            default: ;
        endcase
    end

    // Request with reset_deck: the sweep runs, then shuffle proceeds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else if (state_reg == ST_IDLE && start && reset_deck)
        begin
            pend_reg <= 1'b1;
        end
        else if (state_reg == ST_INIT && 32'(i_reg) == DECK_SIZE - 1)
        begin
            pend_reg <= 1'b0;
        end
    end

    // Split the card code into suit and rank; codes past the fourth suit wrap the suit
    always_comb
    begin
        if (code_reg >= 6'(4 * SUIT_LEN))
        begin
            card_suit = 2'd0;
            card_rank = 4'(code_reg - 6'(4 * SUIT_LEN));
        end
        else if (code_reg >= 6'(3 * SUIT_LEN))
        begin
            card_suit = 2'd3;
            card_rank = 4'(code_reg - 6'(3 * SUIT_LEN));
        end
        else if (code_reg >= 6'(2 * SUIT_LEN))
        begin
            card_suit = 2'd2;
            card_rank = 4'(code_reg - 6'(2 * SUIT_LEN));
        end
        else if (code_reg >= 6'(SUIT_LEN))
        begin
            card_suit = 2'd1;
            card_rank = 4'(code_reg - 6'(SUIT_LEN));
        end
        else
        begin
            card_suit = 2'd0;
            card_rank = code_reg[3:0];
        end
    end

    assign strobe    = strobe_reg;
    assign position  = pos_reg;
    assign last_card = last_reg;

`ifndef SYNTHESIS
    a_busy_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy)) else $error("strobe outside request");
    a_n_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWAP) |-> (n_reg >= 7'd2)) else $error("deck count");
    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RDA) |-> (k_reg < 6'(n_reg))) else $error("swap index");
`endif
endmodule
